FILE: rtl/mme_pkg.sv
// Shared constants, types and helpers for the matrix multiply engine.
// No dependencies; imported by every module of the engine.
`default_nettype none

package mme_pkg;

    // Geometry and number format
    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;

    // Field and counter widths
    localparam int CFG_W     = 4;
    localparam int CFG_NUM   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = $clog2(STORE_DEPTH);
    localparam int POS_W     = $clog2(STORE_DEPTH + 1);
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;

    // Accumulator: full product plus growth over MAX_DIM terms
    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int ACC_W   = PROD_W + $clog2(MAX_DIM);
    localparam int SHIFT_W = ACC_W - FRAC_BITS;

    // Stream widths
    localparam int IN_DATA_W    = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_FIELD_W  = ROW_W + COL_W + DATA_WIDTH;
    localparam int OUT_DATA_W   = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_USER_W   = 2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } t_cfg_idx;

    // Store write request from the load side
    typedef struct packed {
        logic                   en;
        logic                   sel_b;
        logic [ADDR_W-1:0]      addr;
        logic [DATA_WIDTH-1:0]  data;
    } t_wr_req;

    // Store read request from the sequencer
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
    } t_rd_req;

    // Tag that travels with each product term through the MAC
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_tag;

    // Clamp a size register to the range 1..MAX_DIM
    function automatic logic [CFG_W-1:0] f_eff_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            r = CFG_W'(MAX_DIM);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/matrix_multiply_engine_core.sv
// Top level of the matrix multiply engine: size registers, load positions,
// and the store, MAC and sequencer. Depends on mme_pkg, mme_store, mme_mac, mme_seq.
//
//  channel   | group       | fields (lowest bit first)
//  ----------+-------------+----------------------------------------------------
//  input     | s_axis_*    | tdata: element_value; tuser: which_matrix;
//            |             | tlast: final_element
//  output    | m_axis_*    | tdata: out_row, out_col, product_value;
//            |             | tuser: saturated, size_error; tlast: last_of_run
//  config    | i_cfg_*     | idx 0 a_rows, 1 a_cols, 2 b_rows, 3 b_cols
//
// The final B element of a matching pair of sizes runs the product on the one
// shared multiply-accumulate unit: each element issues a_cols read pairs, then
// drains the pipeline and loads the output register; a size error loads a
// single error output instead. Input is ready only when the sequencer is idle;
// a stalled output holds the sequencer in its push state.
// Reset is synchronous, active low; element stores are not cleared.
`default_nettype none

module matrix_multiply_engine_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [mme_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // element_value
    input  wire logic [0:0]                        s_axis_tuser,  // which_matrix
    input  wire logic                              s_axis_tlast,
    // output stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [mme_pkg::OUT_DATA_W-1:0]         m_axis_tdata,  // out_row, out_col,
                                                                  // product_value
    output logic [mme_pkg::OUT_USER_W-1:0]         m_axis_tuser,  // saturated, size_error
    output logic                                   m_axis_tlast,
    // configuration
    input  wire logic                              i_cfg_we,
    input  wire logic [mme_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [mme_pkg::CFG_W-1:0]         i_cfg_data
);
    import mme_pkg::*;

    logic [CFG_W-1:0] r_cfg [CFG_NUM];
    logic [POS_W-1:0] r_a_pos;
    logic [POS_W-1:0] r_b_pos;

    logic [CFG_W-1:0] a_rows;
    logic [CFG_W-1:0] a_cols;
    logic [CFG_W-1:0] b_rows;
    logic [CFG_W-1:0] b_cols;
    logic [POS_W-1:0] a_size;
    logic [POS_W-1:0] b_size;
    logic             in_xfer;
    logic             to_b;
    logic             start;
    logic             seq_idle;
    t_wr_req          wr;
    t_rd_req          rd;
    t_tag             tag;
    logic [DATA_WIDTH-1:0] a_q;
    logic [DATA_WIDTH-1:0] b_q;
    logic             mac_done;
    logic [DATA_WIDTH-1:0] mac_sum;
    logic             mac_sat;

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < CFG_NUM; n++) begin
                r_cfg[n] <= CFG_W'(MAX_DIM);
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign a_rows = f_eff_dim(r_cfg[CFG_A_ROWS]);
    assign a_cols = f_eff_dim(r_cfg[CFG_A_COLS]);
    assign b_rows = f_eff_dim(r_cfg[CFG_B_ROWS]);
    assign b_cols = f_eff_dim(r_cfg[CFG_B_COLS]);
    assign a_size = POS_W'(a_rows) * POS_W'(a_cols);
    assign b_size = POS_W'(b_rows) * POS_W'(b_cols);

    assign s_axis_tready = seq_idle;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign to_b          = s_axis_tuser[0];
    assign start         = in_xfer && to_b && s_axis_tlast;

    // Store write for a transfer that still fits its matrix
    always_comb begin
        wr.sel_b = to_b;
        wr.data  = s_axis_tdata[DATA_WIDTH-1:0];
        if (to_b) begin
            wr.en   = in_xfer && (r_b_pos < b_size);
            wr.addr = r_b_pos[ADDR_W-1:0];
        end else begin
            wr.en   = in_xfer && (r_a_pos < a_size);
            wr.addr = r_a_pos[ADDR_W-1:0];
        end
    end

    // Advance load positions; drop both back to zero on a final B element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_pos <= '0;
            r_b_pos <= '0;
        end else if (start) begin
            r_a_pos <= '0;
            r_b_pos <= '0;
        end else if (wr.en) begin
            if (to_b) begin
                r_b_pos <= r_b_pos + POS_W'(1);
            end else begin
                r_a_pos <= r_a_pos + POS_W'(1);
            end
        end
    end

    mme_store u_store (
        .i_clk (i_clk),
        .i_wr  (wr),
        .i_rd  (rd),
        .o_a_q (a_q),
        .o_b_q (b_q)
    );

    mme_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (tag),
        .i_a     (a_q),
        .i_b     (b_q),
        .o_done  (mac_done),
        .o_sum   (mac_sum),
        .o_sat   (mac_sat)
    );

    mme_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_mismatch (a_cols != b_rows),
        .i_a_rows   (a_rows),
        .i_a_cols   (a_cols),
        .i_b_cols   (b_cols),
        .i_mac_done (mac_done),
        .i_mac_sum  (mac_sum),
        .i_mac_sat  (mac_sat),
        .i_m_tready (m_axis_tready),
        .o_idle     (seq_idle),
        .o_rd       (rd),
        .o_tag      (tag),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

FILE: rtl/mme_store.sv
// Element stores for matrices A and B: one write port, one registered read each.
// Depends on mme_pkg.
`default_nettype none

module mme_store (
    input  wire logic                           i_clk,
    input  wire mme_pkg::t_wr_req               i_wr,
    input  wire mme_pkg::t_rd_req               i_rd,
    output logic [mme_pkg::DATA_WIDTH-1:0]      o_a_q,
    output logic [mme_pkg::DATA_WIDTH-1:0]      o_b_q
);
    import mme_pkg::*;

    logic [DATA_WIDTH-1:0] r_a_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] r_b_mem [STORE_DEPTH];
    logic [DATA_WIDTH-1:0] r_a_q;
    logic [DATA_WIDTH-1:0] r_b_q;

    // Write the loaded element into its matrix
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            if (i_wr.sel_b) begin
                r_b_mem[i_wr.addr] <= i_wr.data;
            end else begin
                r_a_mem[i_wr.addr] <= i_wr.data;
            end
        end
    end

    // Read one A and one B element per cycle while the read request is enabled, registered
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_a_q <= r_a_mem[i_rd.a_addr];
            r_b_q <= r_b_mem[i_rd.b_addr];
        end
    end

    assign o_a_q = r_a_q;
    assign o_b_q = r_b_q;

endmodule

`default_nettype wire

FILE: rtl/mme_mac.sv
// Shared multiply-accumulate unit: registered multiply, wide accumulate,
// floor to Q16.16 and saturate. Depends on mme_pkg.
`default_nettype none

module mme_mac (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire mme_pkg::t_tag                  i_tag,
    input  wire logic [mme_pkg::DATA_WIDTH-1:0] i_a,
    input  wire logic [mme_pkg::DATA_WIDTH-1:0] i_b,
    output logic                                o_done,
    output logic [mme_pkg::DATA_WIDTH-1:0]      o_sum,
    output logic                                o_sat
);
    import mme_pkg::*;

    t_tag                     r_rd_tag;
    t_tag                     r_pr_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;

    logic signed [ACC_W-1:0]   prod_ext;
    logic signed [SHIFT_W-1:0] floored;
    logic [SHIFT_W-DATA_WIDTH:0] top_bits;
    logic                      fits;

    // Align tags with the store read data, then with the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
            r_pr_tag <= '0;
            r_done   <= 1'b0;
        end else begin
            r_rd_tag <= i_tag;
            r_pr_tag <= r_rd_tag;
            r_done   <= r_pr_tag.vld && r_pr_tag.last;
        end
    end

    // Multiply one term
    always_ff @(posedge i_clk) begin
        if (r_rd_tag.vld) begin
            r_prod <= $signed(i_a) * $signed(i_b);
        end
    end

    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // Accumulate exact products; restart on the first term
    always_ff @(posedge i_clk) begin
        if (r_pr_tag.vld) begin
            if (r_pr_tag.first) begin
                r_acc <= prod_ext;
            end else begin
                r_acc <= r_acc + prod_ext;
            end
        end
    end

    // Floor away the fraction, then clip to the data width
    assign floored  = SHIFT_W'(r_acc >>> FRAC_BITS);
    assign top_bits = floored[SHIFT_W-1:DATA_WIDTH-1];
    assign fits     = (top_bits == '0) || (top_bits == '1);

    always_comb begin
        if (fits) begin
            o_sum = floored[DATA_WIDTH-1:0];
        end else if (floored[SHIFT_W-1]) begin
            o_sum = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    end

    assign o_sat  = !fits;
    assign o_done = r_done;

endmodule

`default_nettype wire

FILE: rtl/mme_seq.sv
// Product sequencer: walks rows, columns and the inner index, feeds the MAC,
// and holds the output stream register. Depends on mme_pkg.
`default_nettype none

module mme_seq (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic                           i_mismatch,
    input  wire logic [mme_pkg::CFG_W-1:0]      i_a_rows,
    input  wire logic [mme_pkg::CFG_W-1:0]      i_a_cols,
    input  wire logic [mme_pkg::CFG_W-1:0]      i_b_cols,
    input  wire logic                           i_mac_done,
    input  wire logic [mme_pkg::DATA_WIDTH-1:0] i_mac_sum,
    input  wire logic                           i_mac_sat,
    input  wire logic                           i_m_tready,
    output logic                                o_idle,
    output mme_pkg::t_rd_req                    o_rd,
    output mme_pkg::t_tag                       o_tag,
    output logic                                o_m_tvalid,
    output logic [mme_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic [mme_pkg::OUT_USER_W-1:0]      o_m_tuser,
    output logic                                o_m_tlast
);
    import mme_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_PUSH,
        S_ERR
    } t_state;

    t_state                r_state,   n_state;
    logic [IDX_W-1:0]      r_i,       n_i;
    logic [IDX_W-1:0]      r_j,       n_j;
    logic [IDX_W-1:0]      r_k,       n_k;
    logic [ADDR_W-1:0]     r_a_base,  n_a_base;
    logic [ADDR_W-1:0]     r_b_addr,  n_b_addr;
    logic                  r_out_vld, n_out_vld;
    logic [ROW_W-1:0]      r_out_row, n_out_row;
    logic [COL_W-1:0]      r_out_col, n_out_col;
    logic [DATA_WIDTH-1:0] r_out_val, n_out_val;
    logic                  r_out_sat, n_out_sat;
    logic                  r_out_err, n_out_err;
    logic                  r_out_last, n_out_last;

    logic slot_free;
    logic k_last;
    logic j_last;
    logic i_last;

    assign slot_free = !r_out_vld || i_m_tready;
    assign k_last    = CFG_W'(r_k) == (i_a_cols - CFG_W'(1));
    assign j_last    = CFG_W'(r_j) == (i_b_cols - CFG_W'(1));
    assign i_last    = CFG_W'(r_i) == (i_a_rows - CFG_W'(1));

    // Issue one A/B read pair per cycle while walking the inner index
    always_comb begin
        o_rd.en     = (r_state == S_ISSUE);
        o_rd.a_addr = r_a_base + ADDR_W'(r_k);
        o_rd.b_addr = r_b_addr;
        o_tag.vld   = (r_state == S_ISSUE);
        o_tag.first = (r_k == '0);
        o_tag.last  = k_last;
    end

    // Next-state and output register logic
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_a_base   = r_a_base;
        n_b_addr   = r_b_addr;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_val  = r_out_val;
        n_out_sat  = r_out_sat;
        n_out_err  = r_out_err;
        n_out_last = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    n_a_base = '0;
                    n_b_addr = '0;
                    n_state  = i_mismatch ? S_ERR : S_ISSUE;
                end
            end
            S_ISSUE: begin
                n_k      = r_k + IDX_W'(1);
                n_b_addr = r_b_addr + ADDR_W'(i_b_cols);
                if (k_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_mac_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_row  = ROW_W'(r_i);
                    n_out_col  = COL_W'(r_j);
                    n_out_val  = i_mac_sum;
                    n_out_sat  = i_mac_sat;
                    n_out_err  = 1'b0;
                    n_out_last = i_last && j_last;
                    n_k        = '0;
                    // Advance to the next product element, row-major
                    if (j_last) begin
                        n_j      = '0;
                        n_i      = r_i + IDX_W'(1);
                        n_a_base = r_a_base + ADDR_W'(i_a_cols);
                        n_b_addr = '0;
                    end else begin
                        n_j      = r_j + IDX_W'(1);
                        n_b_addr = ADDR_W'(r_j) + ADDR_W'(1);
                    end
                    n_state = (i_last && j_last) ? S_IDLE : S_ISSUE;
                end
            end
            S_ERR: begin
                if (slot_free) begin
                    n_out_vld  = 1'b1;
                    n_out_row  = '0;
                    n_out_col  = '0;
                    n_out_val  = '0;
                    n_out_sat  = 1'b0;
                    n_out_err  = 1'b1;
                    n_out_last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, counters and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_a_base   <= n_a_base;
        r_b_addr   <= n_b_addr;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_val  <= n_out_val;
        r_out_sat  <= n_out_sat;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    assign o_idle     = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}}, r_out_val, r_out_col, r_out_row};
    assign o_m_tuser  = {r_out_err, r_out_sat};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire
